@@ rtl/kvi_pkg.sv @@
// ----------------------------------------------------------------------------
// kvi_pkg
// Shared types and constants for the keyframe vector interpolation unit.
// ----------------------------------------------------------------------------
package kvi_pkg;

  // Default table depth.
  localparam int MAX_KEYS_DEF = 64;

  // Fraction bits of the Q16.16 format and of the interpolation factor.
  localparam int FRAC_BITS = 16;
  localparam int DIV_CNT_W = $clog2(FRAC_BITS + 1);

  // Blend datapath widths.
  localparam int DIFF_W = 33;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int SUM_W  = 35;

  // Request opcodes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Vector component select.
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  // Result classification.
  typedef enum logic [1:0] {
    EDGE_INTERP = 2'd0,
    EDGE_FIRST  = 2'd1,
    EDGE_LAST   = 2'd2
  } kvi_edge_t;

  // Query sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_DIV,
    ST_BLEND,
    ST_DRAIN
  } kvi_state_t;

  // One table entry: key time and vector.
  typedef struct packed {
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } kvi_key_t;

  // Memory write request.
  typedef struct packed {
    logic     en;
    kvi_key_t data;
  } kvi_wr_t;

endpackage

@@ rtl/kvi_key_mem.sv @@
// ----------------------------------------------------------------------------
// kvi_key_mem
// Key table: one write port and one registered read port.
// ----------------------------------------------------------------------------
module kvi_key_mem #(
  parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEF,
  parameter int AW       = $clog2(MAX_KEYS)
) (
  input  logic             clk,
  input  kvi_pkg::kvi_wr_t wr,
  input  logic [AW-1:0]    wr_addr,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output kvi_pkg::kvi_key_t rd_data
);
  import kvi_pkg::*;

  kvi_key_t mem [MAX_KEYS];
  kvi_key_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // Registered read port, enabled by rd_en.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/kvi_divider.sv @@
// ----------------------------------------------------------------------------
// kvi_divider
// Restoring divider producing the Q0.16 interpolation factor one bit a cycle.
// The numerator is known to be below the divisor.
// ----------------------------------------------------------------------------
module kvi_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [31:0]                   num,
  input  logic [31:0]                   den,
  output logic                          done,
  output logic [kvi_pkg::FRAC_BITS-1:0] quo
);
  import kvi_pkg::*;

  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [31:0]          den_r, den_nxt;
  logic [FRAC_BITS-1:0] quo_r, quo_nxt;
  logic [32:0]          shifted;
  logic                 ge;

  // One shift and trial subtract per cycle.
  assign shifted = {rem_r, 1'b0};
  assign ge      = shifted >= {1'b0, den_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = DIV_CNT_W'(FRAC_BITS);
      rem_nxt = num;
      den_nxt = den;
      quo_nxt = '0;
    end else if (run_r) begin
      rem_nxt = ge ? 32'(shifted - {1'b0, den_r}) : shifted[31:0];
      quo_nxt = {quo_r[FRAC_BITS-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ rtl/kvi_blend.sv @@
// ----------------------------------------------------------------------------
// kvi_blend
// Two-stage linear blend of one component: start + floor((end - start) * f
// / 2^16), saturated to 32 bits.
// ----------------------------------------------------------------------------
module kvi_blend (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [31:0]            a,
  input  logic signed [31:0]            b,
  input  logic [kvi_pkg::FRAC_BITS-1:0] f,
  output logic                          out_valid,
  output logic signed [31:0]            res
);
  import kvi_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

  logic                      v1_r, v2_r;
  logic signed [PROD_W-1:0]  p_r, p_nxt;
  logic signed [31:0]        a_r;
  logic signed [31:0]        res_r, res_nxt;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [FRAC_BITS:0] f_s;
  logic signed [SUM_W-1:0]   term;
  logic signed [SUM_W-1:0]   sum;

  // Stage one: difference times factor.
  assign diff  = DIFF_W'(b) - DIFF_W'(a);
  assign f_s   = $signed({1'b0, f});
  assign p_nxt = diff * f_s;

  // Stage two: arithmetic shift floors toward minus infinity, then saturate.
  assign term = SUM_W'(p_r >>> FRAC_BITS);
  assign sum  = term + SUM_W'(a_r);

  always_comb begin
    if (sum > SAT_HI) begin
      res_nxt = 32'sh7FFFFFFF;
    end else if (sum < SAT_LO) begin
      res_nxt = 32'sh80000000;
    end else begin
      res_nxt = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    a_r   <= a;
    res_r <= res_nxt;
  end

  assign out_valid = v2_r;
  assign res       = res_r;

endmodule

@@ rtl/keyframe_vector_interpolation_unit.sv @@
// ----------------------------------------------------------------------------
// keyframe_vector_interpolation_unit
// Keyframe table with linear interpolation of an x, y, z vector over time.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. A load request
//   (in_op = 0) writes one key into the table in the accepting cycle and
//   returns nothing; busy stays low, so loads can stream one per cycle.
//   A query request (in_op = 1) scans the key times from the table memory
//   one entry per cycle, divides for the factor with a 16-step serial
//   divider and blends x, y and z through one shared multiplier.
//   The result appears on the out_ ports for one cycle with out_valid high.
//   A query returns key 0 from the first read, the last of n keys when the
//   scan ends, and otherwise a blend when the time falls in the segment
//   ending at key i. A new request can be taken as soon as busy is low.
//   cfg_wr_en writes key_count; write it only while the unit is idle.
//   Reset sets key_count to 1 and clears the sequencer; table contents stay
//   undefined until loaded. The receiver cannot stall: out_valid is a strobe.
// ----------------------------------------------------------------------------
module keyframe_vector_interpolation_unit #(
  parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [5:0]         in_key_slot,
  input  logic [31:0]        in_time_value,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  output logic               out_valid,
  output logic signed [31:0] out_res_x,
  output logic signed [31:0] out_res_y,
  output logic signed [31:0] out_res_z,
  output logic [1:0]         out_edge_case,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data
);
  import kvi_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int SW = (AW > 6) ? AW + 1 : 7;
  localparam int LW = (AW + 1 > 7) ? AW + 1 : 7;

  kvi_state_t state_r, state_nxt;

  logic [6:0]           key_count_r;
  logic [31:0]          t_r, t_nxt;
  logic [AW-1:0]        last_r, last_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  kvi_key_t             prev_r, prev_nxt;
  kvi_key_t             hi_r, hi_nxt;
  logic [FRAC_BITS-1:0] f_r, f_nxt;
  logic [1:0]           c_r, c_nxt;
  logic [1:0]           rc_r, rc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [31:0]   res_x_r, res_x_nxt;
  logic signed [31:0]   res_y_r, res_y_nxt;
  logic signed [31:0]   res_z_r, res_z_nxt;
  kvi_edge_t            edge_r, edge_nxt;

  logic                 accept;
  logic                 slot_ok;
  logic [LW-1:0]        kc_w;
  logic [AW-1:0]        last_calc;
  kvi_wr_t              mem_wr;
  logic [AW-1:0]        mem_wr_addr;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  kvi_key_t             rd_data;
  logic                 first_hit;
  logic                 found;
  logic                 at_last;
  logic                 div_start;
  logic                 div_done;
  logic [FRAC_BITS-1:0] div_quo;
  logic [31:0]          div_num;
  logic [31:0]          div_den;
  logic                 bl_in_valid;
  logic signed [31:0]   bl_a, bl_b;
  logic                 bl_out_valid;
  logic signed [31:0]   bl_res;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= 7'd1;
    end else if (cfg_wr_en) begin
      key_count_r <= cfg_wr_data;
    end
  end

  // Effective key count, held as the index of the last valid key.
  assign kc_w = LW'(key_count_r);
  always_comb begin
    if (kc_w == '0) begin
      last_calc = '0;
    end else if (kc_w > LW'(MAX_KEYS)) begin
      last_calc = AW'(MAX_KEYS - 1);
    end else begin
      last_calc = AW'(kc_w - 1'b1);
    end
  end

  // Load requests write the table directly.
  assign slot_ok          = SW'(in_key_slot) < SW'(MAX_KEYS);
  assign mem_wr.en        = accept && (in_op == OP_LOAD) && slot_ok;
  assign mem_wr.data.t    = in_time_value;
  assign mem_wr.data.x    = in_vec_x;
  assign mem_wr.data.y    = in_vec_y;
  assign mem_wr.data.z    = in_vec_z;
  assign mem_wr_addr      = AW'(in_key_slot);

  kvi_key_mem #(
    .MAX_KEYS (MAX_KEYS),
    .AW       (AW)
  ) u_key_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .wr_addr (mem_wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Scan decisions on the entry just read.
  assign first_hit = (last_r == '0) || (t_r < rd_data.t);
  assign found     = t_r < rd_data.t;
  assign at_last   = (idx_r == last_r);

  // Factor divide: the segment is prev_r to the entry just read.
  assign div_num = t_r - prev_r.t;
  assign div_den = rd_data.t - prev_r.t;

  kvi_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Component select into the shared blend unit.
  always_comb begin
    case (c_r)
      COMP_X: begin
        bl_a = prev_r.x;
        bl_b = hi_r.x;
      end
      COMP_Y: begin
        bl_a = prev_r.y;
        bl_b = hi_r.y;
      end
      default: begin
        bl_a = prev_r.z;
        bl_b = hi_r.z;
      end
    endcase
  end

  kvi_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (bl_in_valid),
    .a         (bl_a),
    .b         (bl_b),
    .f         (f_r),
    .out_valid (bl_out_valid),
    .res       (bl_res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_QUERY)) begin
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        state_nxt = first_hit ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (found) begin
          state_nxt = ST_DIV;
        end else if (at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (c_r == COMP_Z) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (bl_out_valid && (rc_r == COMP_Z)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: table reads, divider start and blend issue.
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = '0;
    div_start   = 1'b0;
    bl_in_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        rd_en   = accept && (in_op == OP_QUERY);
        rd_addr = '0;
      end
      ST_FIRST: begin
        rd_en   = !first_hit;
        rd_addr = AW'(1);
      end
      ST_SCAN: begin
        rd_en     = !found && !at_last;
        rd_addr   = idx_r + 1'b1;
        div_start = found;
      end
      ST_BLEND: begin
        bl_in_valid = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Datapath register updates.
  always_comb begin
    t_nxt         = t_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    hi_nxt        = hi_r;
    f_nxt         = f_r;
    c_nxt         = c_r;
    rc_nxt        = rc_r;
    out_valid_nxt = 1'b0;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    res_z_nxt     = res_z_r;
    edge_nxt      = edge_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_QUERY)) begin
          t_nxt    = in_time_value;
          last_nxt = last_calc;
        end
      end
      ST_FIRST: begin
        prev_nxt = rd_data;
        idx_nxt  = AW'(1);
        if (first_hit) begin
          out_valid_nxt = 1'b1;
          res_x_nxt     = rd_data.x;
          res_y_nxt     = rd_data.y;
          res_z_nxt     = rd_data.z;
          edge_nxt      = EDGE_FIRST;
        end
      end
      ST_SCAN: begin
        if (found) begin
          hi_nxt = rd_data;
        end else begin
          prev_nxt = rd_data;
          idx_nxt  = idx_r + 1'b1;
          if (at_last) begin
            out_valid_nxt = 1'b1;
            res_x_nxt     = rd_data.x;
            res_y_nxt     = rd_data.y;
            res_z_nxt     = rd_data.z;
            edge_nxt      = EDGE_LAST;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          f_nxt  = div_quo;
          c_nxt  = COMP_X;
          rc_nxt = COMP_X;
        end
      end
      default: begin
        if (state_r == ST_BLEND) begin
          c_nxt = c_r + 1'b1;
        end
        // Blended components return in x, y, z order.
        if (bl_out_valid) begin
          rc_nxt = rc_r + 1'b1;
          case (rc_r)
            COMP_X: res_x_nxt = bl_res;
            COMP_Y: res_y_nxt = bl_res;
            default: begin
              res_z_nxt     = bl_res;
              edge_nxt      = EDGE_INTERP;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      c_r         <= COMP_X;
      rc_r        <= COMP_X;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      c_r         <= c_nxt;
      rc_r        <= rc_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    t_r     <= t_nxt;
    last_r  <= last_nxt;
    idx_r   <= idx_nxt;
    prev_r  <= prev_nxt;
    hi_r    <= hi_nxt;
    f_r     <= f_nxt;
    res_x_r <= res_x_nxt;
    res_y_r <= res_y_nxt;
    res_z_r <= res_z_nxt;
    edge_r  <= edge_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_res_x     = res_x_r;
  assign out_res_y     = res_y_r;
  assign out_res_z     = res_z_r;
  assign out_edge_case = edge_r;

endmodule

@@ test/tb_keyframe_vector_interpolation_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyframe_vector_interpolation_unit
// Self-checking bench for the keyframe interpolation unit. It loads key
// tables, sweeps key_count through its extremes and issues timed queries at
// random pacing. Every returned vector is compared with an untimed prediction
// of the key search, the Q0.16 factor division and the per-component blend.
// ----------------------------------------------------------------------------
module tb_keyframe_vector_interpolation_unit;
  import kvi_pkg::*;

  localparam int NUM_KEYS         = MAX_KEYS_DEF;
  localparam int MAX_GAP          = 18;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 120;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int RANDOM_PHASES    = 10;
  localparam int RANDOM_PER_PHASE = 75;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // One request as the sender presents it, with its lead-in idle cycles.
  typedef struct {
    logic               op;
    logic [5:0]         slot;
    logic [31:0]        t;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    int unsigned        gap;
  } key_req_t;

  // One interpolated vector with its classification.
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    kvi_edge_t          kind;
  } vec_result_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               start         = 1'b0;
  logic               busy;
  logic               in_op         = OP_LOAD;
  logic [5:0]         in_key_slot   = '0;
  logic [31:0]        in_time_value = '0;
  logic signed [31:0] in_vec_x      = '0;
  logic signed [31:0] in_vec_y      = '0;
  logic signed [31:0] in_vec_z      = '0;
  logic               out_valid;
  logic signed [31:0] out_res_x;
  logic signed [31:0] out_res_y;
  logic signed [31:0] out_res_z;
  logic [1:0]         out_edge_case;
  logic               cfg_wr_en     = 1'b0;
  logic [6:0]         cfg_wr_data   = '0;

  keyframe_vector_interpolation_unit #(
    .MAX_KEYS(NUM_KEYS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_key_slot  (in_key_slot),
    .in_time_value(in_time_value),
    .in_vec_x     (in_vec_x),
    .in_vec_y     (in_vec_y),
    .in_vec_z     (in_vec_z),
    .out_valid    (out_valid),
    .out_res_x    (out_res_x),
    .out_res_y    (out_res_y),
    .out_res_z    (out_res_z),
    .out_edge_case(out_edge_case),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // Request and result bookkeeping.
  key_req_t    req_queue[$];
  vec_result_t pending_vectors[$];
  key_req_t    staged_req;
  bit          req_staged       = 1'b0;
  int unsigned gap_left         = 0;
  bit          req_taken        = 1'b0;
  int          reqs_outstanding = 0;

  // Shadow copy of the key table and of key_count.
  logic [31:0]        shadow_time[NUM_KEYS];
  logic signed [31:0] shadow_x[NUM_KEYS];
  logic signed [31:0] shadow_y[NUM_KEYS];
  logic signed [31:0] shadow_z[NUM_KEYS];
  logic [6:0]         shadow_key_count = 7'd1;

  // The stimulus side's view of the key times, used to aim queries and pick load times.
  logic [31:0] plan_time[NUM_KEYS];
  int          plan_count = 1;

  int fail_count   = 0;
  int idle_cycles  = 0;
  int load_count   = 0;
  int query_count  = 0;
  int config_count = 0;
  int edge_hits[3] = '{0, 0, 0};

  initial forever #5 clk = ~clk;

  // Blend one component: start + floor((end - start) * f / 65536), saturated.
  function automatic logic signed [31:0] blend_component(logic signed [31:0] a,
                                                         logic signed [31:0] b,
                                                         logic [15:0] f);
    longint prod;
    longint sum;
    prod = (longint'(b) - longint'(a)) * longint'(f);
    sum  = longint'(a) + (prod >>> FRAC_BITS);
    if (sum > longint'(Q_MAX)) sum = longint'(Q_MAX);
    if (sum < longint'(Q_MIN)) sum = longint'(Q_MIN);
    return sum[31:0];
  endfunction

  // Search the shadow table for the segment around t and interpolate in it.
  function automatic vec_result_t predict_vector(logic [31:0] t);
    vec_result_t r;
    int          n;
    int          hi;
    logic [31:0] span;
    logic [63:0] ratio;
    logic [15:0] f;
    if (shadow_key_count == 0) n = 1;
    else if (shadow_key_count > NUM_KEYS) n = NUM_KEYS;
    else n = int'(shadow_key_count);

    // A single key or a time ahead of key 0 returns key 0.
    if (n == 1 || t < shadow_time[0]) begin
      r = '{shadow_x[0], shadow_y[0], shadow_z[0], EDGE_FIRST};
      return r;
    end
    hi = 1;
    while (hi < n && t >= shadow_time[hi]) hi++;
    // No key time above t: hold the last valid key.
    if (hi == n) begin
      r = '{shadow_x[n-1], shadow_y[n-1], shadow_z[n-1], EDGE_LAST};
      return r;
    end

    span  = shadow_time[hi] - shadow_time[hi-1];
    ratio = (span != 0) ? {16'd0, t - shadow_time[hi-1], 16'd0} / {32'd0, span} : 64'd0;
    f     = (ratio > 64'd65535) ? 16'hFFFF : ratio[15:0];
    r.x    = blend_component(shadow_x[hi-1], shadow_x[hi], f);
    r.y    = blend_component(shadow_y[hi-1], shadow_y[hi], f);
    r.z    = blend_component(shadow_z[hi-1], shadow_z[hi], f);
    r.kind = EDGE_INTERP;
    return r;
  endfunction

  // Vector component: half full range, half extremes and small values.
  function automatic logic signed [31:0] pick_component();
    case ($urandom_range(0, 11))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4, 5:    return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      default: return $urandom;
    endcase
  endfunction

  // Idle cycles ahead of a request; mode 0 streams, 1 always draws, 2 mixes.
  function automatic int unsigned draw_gap(int unsigned mode);
    if (mode == 0) return 0;
    if (mode == 2 && $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void push_load(logic [5:0] slot, logic [31:0] t, logic signed [31:0] x,
                                    logic signed [31:0] y, logic signed [31:0] z,
                                    int unsigned gap);
    key_req_t r;
    r = '{OP_LOAD, slot, t, x, y, z, gap};
    req_queue = {req_queue, r};
    reqs_outstanding++;
    plan_time[slot] = t;
  endfunction

  function automatic void push_query(logic [31:0] t, int unsigned gap);
    key_req_t r;
    r = '{OP_QUERY, 6'd0, t, 32'sd0, 32'sd0, 32'sd0, gap};
    req_queue = {req_queue, r};
    reqs_outstanding++;
  endfunction

  // Write all slots with non-decreasing times; repeated times and gaps of
  // very different sizes keep the division and the search busy.
  function automatic void fill_sorted_table(bit high_base, int unsigned mode);
    logic [31:0] t;
    t = high_base ? $urandom_range(0, 32'hB000_0000) : $urandom_range(0, 255);
    for (int s = 0; s < NUM_KEYS; s++) begin
      push_load(6'(s), t, pick_component(), pick_component(), pick_component(),
                draw_gap(mode));
      case ($urandom_range(0, 3))
        0:       t = t;
        1:       t = t + $urandom_range(1, 16);
        2:       t = t + $urandom_range(1, 32'h1_0000);
        default: t = t + $urandom_range(1, 32'h100_0000);
      endcase
    end
  endfunction

  // Mostly queries aimed inside a segment, plus key hits, out-of-range times,
  // vector rewrites and the odd load that breaks the time order.
  function automatic void push_random_item(int unsigned mode);
    int unsigned sel;
    int unsigned k;
    int unsigned s;
    logic [31:0] t;
    logic [31:0] lo;
    logic [31:0] hi;
    if ($urandom_range(0, 4) != 0) begin
      sel = $urandom_range(0, 9);
      if (sel < 6 && plan_count > 1) begin
        k  = $urandom_range(0, plan_count - 2);
        lo = plan_time[k];
        hi = plan_time[k+1];
        t  = (hi > lo) ? lo + $urandom_range(0, hi - lo - 1) : lo;
      end else if (sel < 7) begin
        t = plan_time[$urandom_range(0, plan_count - 1)];
      end else if (sel == 7) begin
        t = $urandom_range(0, plan_time[0]);
      end else if (sel == 8) begin
        t = plan_time[plan_count-1] + $urandom_range(0, 255);
      end else begin
        t = $urandom;
      end
      push_query(t, draw_gap(mode));
    end else begin
      s   = $urandom_range(0, NUM_KEYS - 1);
      sel = $urandom_range(0, 3);
      if (sel < 2) begin
        t = plan_time[s];
      end else if (sel == 2 || s == 0 || s == NUM_KEYS - 1) begin
        t = $urandom;
      end else begin
        lo = plan_time[s-1];
        hi = plan_time[s+1];
        t  = (hi > lo) ? lo + $urandom_range(0, hi - lo) : lo;
      end
      push_load(6'(s), t, pick_component(), pick_component(), pick_component(),
                draw_gap(mode));
    end
  endfunction

  function automatic logic [6:0] phase_key_count(int p);
    case (p)
      0:       return 7'd127;
      1:       return 7'd64;
      2:       return 7'd1;
      3:       return 7'd0;
      4:       return 7'd2;
      5:       return 7'd3;
      6:       return 7'd63;
      default: return 7'($urandom_range(4, 127));
    endcase
  endfunction

  // Wait until every request is taken and every result is back, then settle.
  task automatic wait_for_idle();
    while (reqs_outstanding != 0 || pending_vectors.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Called at a falling edge while the unit is idle.
  task automatic write_key_count(logic [6:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    config_count++;
    if (value == 0) plan_count = 1;
    else if (value > NUM_KEYS) plan_count = NUM_KEYS;
    else plan_count = int'(value);
  endtask

  // Request driver: holds a request until it is taken, then stages the next.
  always @(negedge clk) begin
    if (rst_n && !(start && !req_taken)) begin
      if (!req_staged && req_queue.size() != 0) begin
        staged_req = req_queue.pop_front();
        req_staged = 1'b1;
        gap_left   = staged_req.gap;
      end
      if (req_staged && gap_left == 0) begin
        start         <= 1'b1;
        in_op         <= staged_req.op;
        in_key_slot   <= staged_req.slot;
        in_time_value <= staged_req.t;
        in_vec_x      <= staged_req.x;
        in_vec_y      <= staged_req.y;
        in_vec_z      <= staged_req.z;
        req_staged    = 1'b0;
      end else begin
        start <= 1'b0;
        if (gap_left != 0) gap_left--;
      end
    end
  end

  // Result monitor: tracks the table, predicts each query and checks results.
  always @(posedge clk) begin : result_check
    vec_result_t want;
    if (!rst_n) begin
      shadow_key_count = 7'd1;
      req_taken        = 1'b0;
    end else begin
      req_taken = start && !busy;
      if (cfg_wr_en) shadow_key_count = cfg_wr_data;

      if (out_valid) begin
        if (pending_vectors.size() == 0) begin
          $error("result with no query outstanding: x %h y %h z %h edge_case %0d",
                 out_res_x, out_res_y, out_res_z, out_edge_case);
          fail_count++;
        end else begin
          want = pending_vectors.pop_front();
          if (out_res_x !== want.x) begin
            $error("res_x mismatch: expected %h, actual %h", want.x, out_res_x);
            fail_count++;
          end
          if (out_res_y !== want.y) begin
            $error("res_y mismatch: expected %h, actual %h", want.y, out_res_y);
            fail_count++;
          end
          if (out_res_z !== want.z) begin
            $error("res_z mismatch: expected %h, actual %h", want.z, out_res_z);
            fail_count++;
          end
          if (out_edge_case !== want.kind) begin
            $error("edge_case mismatch: expected %0d, actual %0d", want.kind, out_edge_case);
            fail_count++;
          end
          edge_hits[want.kind]++;
        end
      end

      if (req_taken) begin
        reqs_outstanding--;
        if (in_op == OP_LOAD) begin
          shadow_time[in_key_slot] = in_time_value;
          shadow_x[in_key_slot]    = in_vec_x;
          shadow_y[in_key_slot]    = in_vec_y;
          shadow_z[in_key_slot]    = in_vec_z;
          load_count++;
        end else begin
          pending_vectors = {pending_vectors, predict_vector(in_time_value)};
          query_count++;
        end
      end

      // Watchdog on cycles where neither a request nor a result moves.
      if (req_taken || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no request or result for %0d cycles.", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stimulus: directed corner cases first, then randomized phases.
  initial begin : stimulus
    int unsigned mode;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value of key_count: only key 0 is ever returned.
    push_load(6'd0, 32'h0001_0000, Q_MAX, Q_MIN, 32'sd0, 0);
    push_query(32'h0000_0000, 0);
    push_query(32'hFFFF_FFFF, 3);
    push_query(32'h0001_0000, 0);
    wait_for_idle();

    // A count of zero behaves as a single key.
    write_key_count(7'd0);
    @(posedge clk);
    push_query(32'h8000_0000, 0);
    wait_for_idle();

    // Two keys spanning the full signed range: below, on, inside and past.
    write_key_count(7'd2);
    @(posedge clk);
    push_load(6'd1, 32'h0003_0000, Q_MIN, Q_MAX, -32'sd1, 0);
    push_query(32'h0000_FFFF, 0);
    push_query(32'h0001_0000, 1);
    push_query(32'h0002_0000, 0);
    push_query(32'h0002_FFFF, 0);
    push_query(32'h0003_0000, 2);
    push_query(32'hFFFF_FFFF, 0);

    // Widest possible segment; the factor reaches its top value.
    push_load(6'd0, 32'h0000_0000, Q_MIN, 32'sd0, Q_MAX, 1);
    push_load(6'd1, 32'hFFFF_FFFF, Q_MAX, 32'sd1, Q_MIN, 0);
    push_query(32'hFFFF_FFFE, 0);
    push_query(32'h0000_0000, 0);
    push_query(32'h8000_0000, 2);

    // Key times out of order: the search falls through to the last key.
    push_load(6'd0, 32'd5, 32'sd100, -32'sd100, 32'sd7, 0);
    push_load(6'd1, 32'd0, -32'sd100, 32'sd100, -32'sd7, 0);
    push_query(32'd7, 0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_for_idle();
      write_key_count(phase_key_count(p));
      @(posedge clk);
      mode = p % 3;
      fill_sorted_table(p % 2 == 1, mode);
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        // Halfway through, let everything drain before sending more.
        if (k == RANDOM_PER_PHASE / 2) begin
          wait_for_idle();
          @(posedge clk);
        end
        push_random_item(mode);
      end
    end

    wait_for_idle();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Run covered %0d loads and %0d queries across %0d key_count writes.",
             load_count, query_count, config_count);
    $display("Results: %0d interpolated, %0d first key, %0d last key; %0d mismatches.",
             edge_hits[EDGE_INTERP], edge_hits[EDGE_FIRST], edge_hits[EDGE_LAST],
             fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/kvi_pkg.sv
rtl/kvi_key_mem.sv
rtl/kvi_divider.sv
rtl/kvi_blend.sv
rtl/keyframe_vector_interpolation_unit.sv
test/tb_keyframe_vector_interpolation_unit.sv
